/* hdl/ffsa_pkg.sv */
`default_nettype none

package ffsa_pkg;

  // Store geometry
  localparam int FLOORS          = 8;
  localparam int SLOTS_PER_FLOOR = 64;
  localparam int DEPTH           = FLOORS * SLOTS_PER_FLOOR;

  localparam int FLOOR_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int SLOT_W  = $clog2(SLOTS_PER_FLOOR);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int EF_W    = $clog2(FLOORS + 1);
  localparam int ES_W    = $clog2(SLOTS_PER_FLOOR + 1);

  // Field widths
  localparam int ID_W    = 8;
  localparam int TAG_W   = ID_W + 1;
  localparam int FREE_W  = 7;
  localparam int CFG_W   = 7;

  localparam logic [FREE_W-1:0] FREE_MAX = '1;

  // Configuration register reset values
  localparam logic [3:0] FLOORS_IN_USE_RST = 4'd8;
  localparam logic [6:0] SLOTS_IN_USE_RST  = 7'd64;

  typedef logic [TAG_W-1:0] tag_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_SINGLE = 1'b0,
    KIND_PAIR   = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_FLOORS_IN_USE = 1'b0,
    CFG_SLOTS_IN_USE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE2,
    ST_COUNT,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t              op;
    kind_t            size_kind;
    logic [ID_W-1:0]  vehicle_id;
  } in_item_t;

  typedef struct packed {
    logic              success;
    logic [2:0]        floor_index;
    logic [5:0]        slot_index;
    logic [FREE_W-1:0] free_on_floor;
    logic              pair_used;
  } out_item_t;

  // Linear store address of a floor and slot
  function automatic logic [ADDR_W-1:0] addr_of(logic [FLOOR_W-1:0] f,
                                                logic [SLOT_W-1:0] s);
    return ADDR_W'(f * SLOTS_PER_FLOOR) + ADDR_W'(s);
  endfunction

endpackage

`default_nettype wire

/* hdl/first_fit_slot_allocator.sv */
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------
// in       | in_valid / in_stall  | in_data  (op, size_kind, vehicle_id)
// out      | out_valid / out_stall| out_data (success, floor, slot, free, pair)
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request at a time. An allocate walks the store one entry a cycle through
// the single read port until the first fit, then recounts that floor; a
// release walks every searched entry and then recounts the floor of the first
// match. After reset a clearing pass writes zero to all DEPTH (512) entries,
// one per cycle, with in_stall high; cfg writes are taken at any time. A
// stalled result is held in the output register while the next request is
// already taken.

module first_fit_slot_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ffsa_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ffsa_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire ffsa_pkg::cfg_reg_t            cfg_index,
  input  wire logic [ffsa_pkg::CFG_W-1:0]    cfg_data
);

  localparam int FW = ffsa_pkg::FLOOR_W;
  localparam int SW = ffsa_pkg::SLOT_W;
  localparam int AW = ffsa_pkg::ADDR_W;

  // Owner store
  ffsa_pkg::tag_t mem [ffsa_pkg::DEPTH];
  ffsa_pkg::tag_t mem_rdata;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  ffsa_pkg::tag_t mem_wdata;
  logic [AW-1:0]  mem_raddr;

  // Control
  ffsa_pkg::state_t state, state_next;
  logic [3:0]       floors_in_use;
  logic [6:0]       slots_in_use;
  logic [AW-1:0]    clr_addr, clr_addr_next;
  logic             out_valid_next;

  // Request
  ffsa_pkg::op_t    req_op, req_op_next;
  ffsa_pkg::kind_t  req_kind, req_kind_next;
  ffsa_pkg::tag_t   req_tag, req_tag_next;
  logic [FW-1:0]    nf_m1, nf_m1_next;
  logic [SW-1:0]    ns_m1, ns_m1_next;

  // Walk
  logic [FW-1:0]    rd_f, rd_f_next;
  logic [SW-1:0]    rd_s, rd_s_next;
  logic             issue_on, issue_on_next;
  logic             d_vld, d_vld_next;
  logic [FW-1:0]    d_f, d_f_next;
  logic [SW-1:0]    d_s, d_s_next;
  logic             prev_free, prev_free_next;
  logic             pend_pair, pend_pair_next;
  logic             found, found_next;

  // Result
  logic                        res_ok, res_ok_next;
  logic [FW-1:0]               res_f, res_f_next;
  logic [SW-1:0]               res_s, res_s_next;
  logic                        res_pair, res_pair_next;
  logic [ffsa_pkg::FREE_W-1:0] cnt, cnt_next;
  ffsa_pkg::out_item_t         out_data_next;

  // Events
  logic [ffsa_pkg::EF_W-1:0] nf;
  logic [ffsa_pkg::ES_W-1:0] ns;
  logic req_bad, data_free, data_match, last_data, issue_last;
  logic hit_single, hit_pair, rel_first, cnt_last, out_free, go_count;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ffsa_pkg::ST_IDLE);

  // Store ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  assign mem_raddr = ffsa_pkg::addr_of(rd_f, rd_s);

  // Decode conditions shared by control and datapath
  always_comb begin
    nf = (int'(floors_in_use) < ffsa_pkg::FLOORS) ? ffsa_pkg::EF_W'(floors_in_use)
                                                  : ffsa_pkg::EF_W'(ffsa_pkg::FLOORS);
    ns = (int'(slots_in_use) < ffsa_pkg::SLOTS_PER_FLOOR)
         ? ffsa_pkg::ES_W'(slots_in_use) : ffsa_pkg::ES_W'(ffsa_pkg::SLOTS_PER_FLOOR);
    req_bad    = (in_data.vehicle_id == '0) || (nf == '0) || (ns == '0);
    data_free  = (mem_rdata == '0);
    data_match = (mem_rdata == req_tag);
    last_data  = d_vld && (d_f == nf_m1) && (d_s == ns_m1);
    issue_last = (rd_s == ns_m1) && ((state == ffsa_pkg::ST_COUNT) || (rd_f == nf_m1));
    hit_single = (req_op == ffsa_pkg::OP_ALLOC) && (req_kind == ffsa_pkg::KIND_SINGLE)
                 && d_vld && data_free;
    hit_pair   = (req_op == ffsa_pkg::OP_ALLOC) && (req_kind == ffsa_pkg::KIND_PAIR)
                 && d_vld && data_free && prev_free && (d_s != '0);
    rel_first  = (req_op == ffsa_pkg::OP_RELEASE) && d_vld && data_match && !found;
    cnt_last   = d_vld && (d_s == ns_m1);
    out_free   = !out_valid || !out_stall;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffsa_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(ffsa_pkg::DEPTH - 1)) state_next = ffsa_pkg::ST_IDLE;
      end
      ffsa_pkg::ST_IDLE: begin
        if (in_valid) state_next = req_bad ? ffsa_pkg::ST_DONE : ffsa_pkg::ST_SCAN;
      end
      ffsa_pkg::ST_SCAN: begin
        priority if (hit_single) begin
          state_next = ffsa_pkg::ST_COUNT;
        end else if (hit_pair) begin
          state_next = ffsa_pkg::ST_WRITE2;
        end else if (last_data) begin
          if ((req_op == ffsa_pkg::OP_RELEASE) && (found || rel_first)) begin
            state_next = ffsa_pkg::ST_COUNT;
          end else begin
            state_next = ffsa_pkg::ST_DONE;
          end
        end
      end
      ffsa_pkg::ST_WRITE2: begin
        state_next = ffsa_pkg::ST_COUNT;
      end
      ffsa_pkg::ST_COUNT: begin
        if (cnt_last) state_next = ffsa_pkg::ST_DONE;
      end
      ffsa_pkg::ST_DONE: begin
        if (out_free) state_next = ffsa_pkg::ST_IDLE;
      end
      default: state_next = ffsa_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and store access
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = ffsa_pkg::addr_of(d_f, d_s);
    mem_wdata      = '0;
    clr_addr_next  = clr_addr;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    req_op_next    = req_op;
    req_kind_next  = req_kind;
    req_tag_next   = req_tag;
    nf_m1_next     = nf_m1;
    ns_m1_next     = ns_m1;
    rd_f_next      = rd_f;
    rd_s_next      = rd_s;
    issue_on_next  = issue_on;
    d_vld_next     = 1'b0;
    d_f_next       = d_f;
    d_s_next       = d_s;
    prev_free_next = prev_free;
    pend_pair_next = pend_pair;
    found_next     = found;
    res_ok_next    = res_ok;
    res_f_next     = res_f;
    res_s_next     = res_s;
    res_pair_next  = res_pair;
    cnt_next       = cnt;
    go_count       = (state_next == ffsa_pkg::ST_COUNT) && (state != ffsa_pkg::ST_COUNT);

    unique case (state)
      ffsa_pkg::ST_CLEAR: begin
        // Zero one entry per cycle
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
      end
      ffsa_pkg::ST_IDLE: begin
        // Take the request and start the walk at floor 0, slot 0
        if (in_valid) begin
          req_op_next    = in_data.op;
          req_kind_next  = in_data.size_kind;
          req_tag_next   = {in_data.size_kind, in_data.vehicle_id};
          nf_m1_next     = FW'(nf - 1'b1);
          ns_m1_next     = SW'(ns - 1'b1);
          rd_f_next      = '0;
          rd_s_next      = '0;
          issue_on_next  = 1'b1;
          prev_free_next = 1'b0;
          pend_pair_next = 1'b0;
          found_next     = 1'b0;
          res_ok_next    = 1'b0;
          res_f_next     = '0;
          res_s_next     = '0;
          res_pair_next  = 1'b0;
          cnt_next       = '0;
        end
      end
      ffsa_pkg::ST_SCAN: begin
        // Issue the next read
        if (issue_on) begin
          d_vld_next = 1'b1;
          d_f_next   = rd_f;
          d_s_next   = rd_s;
          if (rd_s == ns_m1) begin
            rd_s_next = '0;
            rd_f_next = rd_f + 1'b1;
          end else begin
            rd_s_next = rd_s + 1'b1;
          end
          if (issue_last) issue_on_next = 1'b0;
        end
        // Examine the entry read last cycle
        if (d_vld) begin
          if (req_op == ffsa_pkg::OP_ALLOC) begin
            prev_free_next = data_free;
            if (hit_single || hit_pair) begin
              mem_we      = 1'b1;
              mem_wdata   = req_tag;
              res_ok_next = 1'b1;
              res_f_next  = d_f;
              res_s_next  = hit_pair ? SW'(d_s - 1'b1) : d_s;
              res_pair_next = hit_pair;
            end
          end else begin
            if (pend_pair) begin
              res_pair_next  = data_match && (d_s != '0);
              pend_pair_next = 1'b0;
            end
            if (data_match) begin
              mem_we = 1'b1;
              if (!found) begin
                found_next     = 1'b1;
                res_ok_next    = 1'b1;
                res_f_next     = d_f;
                res_s_next     = d_s;
                pend_pair_next = 1'b1;
              end
            end
          end
        end
      end
      ffsa_pkg::ST_WRITE2: begin
        // Tag the lower slot of the pair
        mem_we    = 1'b1;
        mem_waddr = ffsa_pkg::addr_of(res_f, res_s);
        mem_wdata = req_tag;
      end
      ffsa_pkg::ST_COUNT: begin
        // Walk the result floor and count free slots
        if (issue_on) begin
          d_vld_next = 1'b1;
          d_s_next   = rd_s;
          rd_s_next  = rd_s + 1'b1;
          if (issue_last) issue_on_next = 1'b0;
        end
        if (d_vld && data_free && (cnt != ffsa_pkg::FREE_MAX)) begin
          cnt_next = cnt + 1'b1;
        end
      end
      ffsa_pkg::ST_DONE: begin
        // Hand the result to the output register
        if (out_free) begin
          out_valid_next              = 1'b1;
          out_data_next.success       = res_ok;
          out_data_next.floor_index   = 3'(res_f);
          out_data_next.slot_index    = 6'(res_s);
          out_data_next.free_on_floor = cnt;
          out_data_next.pair_used     = res_pair;
        end
      end
      default: begin
        clr_addr_next = '0;
      end
    endcase

    // Restart the walk on the result floor for the recount
    if (go_count) begin
      rd_f_next     = res_f_next;
      rd_s_next     = '0;
      d_f_next      = res_f_next;
      issue_on_next = 1'b1;
      d_vld_next    = 1'b0;
      cnt_next      = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ffsa_pkg::ST_CLEAR;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      issue_on      <= 1'b0;
      d_vld         <= 1'b0;
      floors_in_use <= ffsa_pkg::FLOORS_IN_USE_RST;
      slots_in_use  <= ffsa_pkg::SLOTS_IN_USE_RST;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
      issue_on  <= issue_on_next;
      d_vld     <= d_vld_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ffsa_pkg::CFG_FLOORS_IN_USE: floors_in_use <= cfg_data[3:0];
          ffsa_pkg::CFG_SLOTS_IN_USE:  slots_in_use  <= cfg_data[6:0];
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data  <= out_data_next;
    req_op    <= req_op_next;
    req_kind  <= req_kind_next;
    req_tag   <= req_tag_next;
    nf_m1     <= nf_m1_next;
    ns_m1     <= ns_m1_next;
    rd_f      <= rd_f_next;
    rd_s      <= rd_s_next;
    d_f       <= d_f_next;
    d_s       <= d_s_next;
    prev_free <= prev_free_next;
    pend_pair <= pend_pair_next;
    found     <= found_next;
    res_ok    <= res_ok_next;
    res_f     <= res_f_next;
    res_s     <= res_s_next;
    res_pair  <= res_pair_next;
    cnt       <= cnt_next;
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
module testbench;

  localparam int IDLE_LIMIT = 5000;  // cycles with no transfer on any channel
  localparam int SETTLE     = 20;    // quiet cycles before a register write
  localparam int TAIL_WAIT  = 600;   // about one full store walk plus recount

  logic clk = 1'b0;
  logic rst;

  logic                          in_valid;
  logic                          in_stall;
  ffsa_pkg::in_item_t            in_data;
  logic                          out_valid;
  logic                          out_stall;
  ffsa_pkg::out_item_t           out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  ffsa_pkg::cfg_reg_t            cfg_index;
  logic [ffsa_pkg::CFG_W-1:0]    cfg_data;

  // Requests waiting to be driven, results waiting to be seen
  ffsa_pkg::in_item_t  request_queue[$];
  ffsa_pkg::out_item_t awaited_results[$];
  ffsa_pkg::tag_t      live_tags[$];

  // Shadow of the block: owner tags and search bounds
  ffsa_pkg::tag_t owner_tag[ffsa_pkg::DEPTH];
  logic [3:0]     floors_reg;
  logic [6:0]     slots_reg;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic in_took;
  int   cfg_writes;
  int   quiet_cycles;
  int   errors;

  first_fit_slot_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Serve one request against the shadow store and return its result
  function automatic ffsa_pkg::out_item_t serve_request(ffsa_pkg::in_item_t req);
    ffsa_pkg::out_item_t res;
    ffsa_pkg::tag_t      tag;
    int                  nf, ns, a, rf, rs, nfree;
    bit                  found, pair;
    res   = '0;
    tag   = ffsa_pkg::tag_t'({req.size_kind, req.vehicle_id});
    nf    = (floors_reg < ffsa_pkg::FLOORS) ? int'(floors_reg) : ffsa_pkg::FLOORS;
    ns    = (slots_reg < ffsa_pkg::SLOTS_PER_FLOOR) ? int'(slots_reg)
                                                    : ffsa_pkg::SLOTS_PER_FLOOR;
    found = 1'b0;
    pair  = 1'b0;
    rf    = 0;
    rs    = 0;
    if (req.vehicle_id == '0) return res;
    if (req.op == ffsa_pkg::OP_ALLOC) begin
      // first fit, floor then slot; a pair stays inside the searched slots
      for (int f = 0; f < nf && !found; f++) begin
        for (int s = 0; s < ns && !found; s++) begin
          a = f * ffsa_pkg::SLOTS_PER_FLOOR + s;
          if (owner_tag[a] == '0) begin
            if (req.size_kind == ffsa_pkg::KIND_SINGLE) begin
              owner_tag[a] = tag;
              found = 1'b1;
            end else if (s + 1 < ns && owner_tag[a + 1] == '0) begin
              owner_tag[a]     = tag;
              owner_tag[a + 1] = tag;
              found = 1'b1;
              pair  = 1'b1;
            end
            if (found) begin
              rf = f;
              rs = s;
            end
          end
        end
      end
    end else begin
      // free every match, report the first one
      for (int f = 0; f < nf; f++) begin
        for (int s = 0; s < ns; s++) begin
          a = f * ffsa_pkg::SLOTS_PER_FLOOR + s;
          if (owner_tag[a] == tag) begin
            if (!found) begin
              found = 1'b1;
              rf    = f;
              rs    = s;
              pair  = (s + 1 < ns) && (owner_tag[a + 1] == tag);
            end
            owner_tag[a] = '0;
          end
        end
      end
    end
    if (found) begin
      nfree = 0;
      for (int s = 0; s < ns; s++)
        if (owner_tag[rf * ffsa_pkg::SLOTS_PER_FLOOR + s] == '0) nfree++;
      res.success       = 1'b1;
      res.floor_index   = 3'(rf);
      res.slot_index    = 6'(rs);
      res.free_on_floor = (nfree > 127) ? ffsa_pkg::FREE_MAX : ffsa_pkg::FREE_W'(nfree);
      res.pair_used     = pair;
    end
    return res;
  endfunction

  // Drive requests and receiver stall on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= request_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Sample transfers on the rising edge, predict and check
  always @(posedge clk) begin : monitor_blk
    bit                  moved;
    ffsa_pkg::out_item_t want;
    if (rst) begin
      in_took      <= 1'b0;
      quiet_cycles <= 0;
      floors_reg   <= ffsa_pkg::FLOORS_IN_USE_RST;
      slots_reg    <= ffsa_pkg::SLOTS_IN_USE_RST;
      for (int i = 0; i < ffsa_pkg::DEPTH; i++) owner_tag[i] = '0;
    end else begin
      moved = 1'b0;
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        awaited_results.push_back(serve_request(in_data));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          $display("%0t: result expected none got %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          want = awaited_results.pop_front();
          if (out_data !== want) begin
            if (out_data.success !== want.success)
              $display("%0t: success expected %0d got %0d",
                       $time, want.success, out_data.success);
            if (out_data.floor_index !== want.floor_index)
              $display("%0t: floor_index expected %0d got %0d",
                       $time, want.floor_index, out_data.floor_index);
            if (out_data.slot_index !== want.slot_index)
              $display("%0t: slot_index expected %0d got %0d",
                       $time, want.slot_index, out_data.slot_index);
            if (out_data.free_on_floor !== want.free_on_floor)
              $display("%0t: free_on_floor expected %0d got %0d",
                       $time, want.free_on_floor, out_data.free_on_floor);
            if (out_data.pair_used !== want.pair_used)
              $display("%0t: pair_used expected %0d got %0d",
                       $time, want.pair_used, out_data.pair_used);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        cfg_writes <= cfg_writes + 1;
        case (cfg_index)
          ffsa_pkg::CFG_FLOORS_IN_USE: floors_reg <= cfg_data[3:0];
          ffsa_pkg::CFG_SLOTS_IN_USE:  slots_reg  <= cfg_data;
          default: ;
        endcase
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // End the run when nothing moves for too long
  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  function automatic ffsa_pkg::in_item_t mk(ffsa_pkg::op_t o, ffsa_pkg::kind_t k,
                                            logic [ffsa_pkg::ID_W-1:0] id);
    ffsa_pkg::in_item_t it;
    it.op         = o;
    it.size_kind  = k;
    it.vehicle_id = id;
    return it;
  endfunction

  // One register transfer; valid drops after the monitor has counted it
  task automatic write_reg(ffsa_pkg::cfg_reg_t idx, logic [ffsa_pkg::CFG_W-1:0] val);
    int target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (cfg_writes != target);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_bounds(logic [ffsa_pkg::CFG_W-1:0] nf, logic [ffsa_pkg::CFG_W-1:0] ns);
    write_reg(ffsa_pkg::CFG_FLOORS_IN_USE, nf);
    write_reg(ffsa_pkg::CFG_SLOTS_IN_USE, ns);
  endtask

  // Wait for every request to be sent and answered, then let the block settle
  task automatic drain();
    while (request_queue.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly allocate/release pairs of the same owners from a small pool
  task automatic run_random(int n, int pool);
    ffsa_pkg::in_item_t it;
    int                 pick;
    live_tags.delete();
    for (int i = 0; i < n; i++) begin
      it.vehicle_id = ($urandom_range(99) < 85)
                      ? ffsa_pkg::ID_W'($urandom_range(pool, 1))
                      : ffsa_pkg::ID_W'($urandom_range(255, 1));
      it.size_kind  = ffsa_pkg::kind_t'($urandom_range(1));
      if ($urandom_range(99) < 55) begin
        it.op = ffsa_pkg::OP_ALLOC;
        live_tags.push_back(ffsa_pkg::tag_t'({it.size_kind, it.vehicle_id}));
      end else begin
        it.op = ffsa_pkg::OP_RELEASE;
        if (live_tags.size() > 0 && $urandom_range(99) < 75) begin
          pick          = $urandom_range(live_tags.size() - 1);
          it.size_kind  = ffsa_pkg::kind_t'(live_tags[pick][ffsa_pkg::ID_W]);
          it.vehicle_id = live_tags[pick][ffsa_pkg::ID_W-1:0];
          live_tags.delete(pick);
        end
      end
      if ($urandom_range(99) < 3) it.vehicle_id = '0;
      request_queue.push_back(it);
    end
  endtask

  task automatic phase(int nf, int ns, int n, int pool);
    set_bounds(ffsa_pkg::CFG_W'(nf), ffsa_pkg::CFG_W'(ns));
    run_random(n, pool);
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = ffsa_pkg::CFG_FLOORS_IN_USE;
    cfg_data      = '0;
    in_took       = 1'b0;
    cfg_writes    = 0;
    quiet_cycles  = 0;
    errors        = 0;
    send_idle_pct = 28;
    recv_idle_pct = 80;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed: full geometry, extremes of the id, failures on id zero
    set_bounds(8, 64);
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_SINGLE, 8'd255));
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_PAIR,   8'd1));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_SINGLE, 8'd255));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_SINGLE, 8'd77));
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_SINGLE, 8'd0));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_PAIR,   8'd0));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_PAIR,   8'd1));
    drain();

    // Directed: pair refused at the floor end, store full, several matches
    set_bounds(2, 3);
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_SINGLE, 8'd5));
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_SINGLE, 8'd5));
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_PAIR,   8'd9));
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_PAIR,   8'd10));
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_SINGLE, 8'd6));
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_SINGLE, 8'd7));
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_SINGLE, 8'd8));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_SINGLE, 8'd5));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_PAIR,   8'd9));
    drain();

    // Directed: zero bounds search nothing
    set_bounds(0, 64);
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_SINGLE, 8'd3));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_SINGLE, 8'd6));
    drain();
    set_bounds(15, 0);
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_PAIR,   8'd3));
    drain();

    // Directed: bounds beyond the store size
    set_bounds(15, 127);
    request_queue.push_back(mk(ffsa_pkg::OP_ALLOC,   ffsa_pkg::KIND_PAIR,   8'd200));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_SINGLE, 8'd6));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_SINGLE, 8'd7));
    request_queue.push_back(mk(ffsa_pkg::OP_RELEASE, ffsa_pkg::KIND_PAIR,   8'd200));
    drain();

    // Random, sender idles lightly, receiver heavily
    phase(1, 2, 130, 3);
    phase(3, 7, 130, 6);
    phase(8, 64, 100, 40);

    // Random, sender idles heavily, receiver lightly
    send_idle_pct = 80;
    recv_idle_pct = 28;
    phase(15, 127, 100, 20);
    phase(4, 1, 130, 3);
    phase(2, 5, 130, 4);

    // Random, full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase(8, 3, 130, 8);
    phase(1, 64, 130, 30);
    phase(5, 2, 130, 4);
    phase(8, 64, 60, 60);

    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
